@@ hdl/fbsync_pkg.sv @@
// ----------------------------------------------------------------------------
// fbsync_pkg
// Shared constants, codes and types of the frame id barrier sync unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fbsync_pkg;

    localparam int MAX_STREAMS = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int STREAM_W = $clog2(MAX_STREAMS);
    localparam int CNT_W    = $clog2(MAX_STREAMS + 1);
    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W   = STREAM_W + SLOT_W;
    localparam int STORE_DEPTH = MAX_STREAMS * QUEUE_DEPTH;

    localparam int ID_W     = 32;
    localparam int TAG_W    = 16;
    localparam int ENTRY_W  = ID_W + TAG_W;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam int CFG_DATA_W = 5;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_COLLECT = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONMONO  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NEED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FLUSHED  = 3'd6;

    // configuration register indexes
    localparam logic CFG_STREAMS = 1'b0;
    localparam logic CFG_DEPTH   = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STREAM_W-1:0] stream;
        logic [ID_W-1:0]     frm_id;
        logic [TAG_W-1:0]    buffer_tag;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  streams;
        logic [FILL_W-1:0] depth;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STREAM_W-1:0] stream;
        logic [ID_W-1:0]     frm_id;
        logic [TAG_W-1:0]    buffer_tag;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/fbsync_ram.sv @@
// ----------------------------------------------------------------------------
// fbsync_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsync_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/fbsync_front.sv @@
// ----------------------------------------------------------------------------
// fbsync_front
// Input stage: takes requests, drops unknown ops, stages commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsync_front
    import fbsync_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [STREAM_W-1:0] stream,
    input  wire logic [ID_W-1:0]     frm_id,
    input  wire logic [TAG_W-1:0]    buffer_tag,
    output logic                     cmd_valid,
    output cmd_t                     cmd,
    input  wire logic                q_full
);

    logic stage_valid_reg;
    logic stage_valid_next;
    cmd_t stage_reg;
    logic load;

    assign in_stall  = stage_valid_reg && q_full;
    // unknown op is taken and dropped here
    assign load      = in_valid && !in_stall && (op != OP_NONE);
    assign cmd_valid = stage_valid_reg;
    assign cmd       = stage_reg;

    assign stage_valid_next = load || (stage_valid_reg && q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= '{op: op, stream: stream, frm_id: frm_id, buffer_tag: buffer_tag};
        end
    end

endmodule

`default_nettype wire

@@ hdl/fbsync_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// fbsync_cmd_queue
// Short command queue decoupling the front stage from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsync_cmd_queue
    import fbsync_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  cmd_t      push_data,
    output logic      full,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_data
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic [CMDQ_CNT_W-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/fbsync_back.sv @@
// ----------------------------------------------------------------------------
// fbsync_back
// Execution end: per-stream queue state, entry store, collect sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsync_back
    import fbsync_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic q_valid,
    input  cmd_t      q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output res_t      res
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECIDE  = 3'd1;
    localparam logic [2:0] S_CMP     = 3'd2;
    localparam logic [2:0] S_VERDICT = 3'd3;
    localparam logic [2:0] S_REL     = 3'd4;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    cmd_t                cmd_reg;
    cmd_t                cmd_next;
    logic [STREAM_W-1:0] idx_reg;
    logic [STREAM_W-1:0] idx_next;
    logic [ID_W-1:0]     ref_reg;
    logic [ID_W-1:0]     ref_next;
    logic                mism_reg;
    logic                mism_next;
    logic [FILL_W-1:0]   fill_reg [MAX_STREAMS];
    logic [FILL_W-1:0]   fill_next [MAX_STREAMS];
    logic [SLOT_W-1:0]   head_reg [MAX_STREAMS];
    logic [SLOT_W-1:0]   head_next [MAX_STREAMS];
    logic [ID_W-1:0]     tail_reg [MAX_STREAMS];
    logic [ID_W-1:0]     tail_next [MAX_STREAMS];

    logic                out_valid_reg;
    logic                out_valid_next;
    res_t                res_reg;
    res_t                res_new;
    logic                emit;
    logic                out_free;

    logic [STREAM_W-1:0] rd_stream;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [ID_W-1:0]     rd_id;
    logic [TAG_W-1:0]    rd_tag;
    logic                we;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    logic [STREAM_W-1:0] last_idx;
    logic                any_empty;
    logic                some_full;
    logic [FILL_W-1:0]   s_fill;
    logic                push_refused;
    logic                push_dropped;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign last_idx  = STREAM_W'(cfg.streams - 1'b1);
    assign rd_addr   = {rd_stream, head_reg[rd_stream]};
    assign rd_id     = rd_data[ENTRY_W-1:TAG_W];
    assign rd_tag    = rd_data[TAG_W-1:0];
    assign wr_addr   = {cmd_reg.stream, head_reg[cmd_reg.stream] + s_fill[SLOT_W-1:0]};
    assign wr_data   = {cmd_reg.frm_id, cmd_reg.buffer_tag};

    assign s_fill       = fill_reg[cmd_reg.stream];
    assign push_refused = ({1'b0, cmd_reg.stream} >= cfg.streams) || (s_fill >= cfg.depth);
    assign push_dropped = (s_fill != '0) && (cmd_reg.frm_id <= tail_reg[cmd_reg.stream]);

    always_comb
    begin
        any_empty = 1'b0;
        some_full = 1'b0;
        for (int i = 0; i < MAX_STREAMS; i++)
        begin
            if (CNT_W'(i) < cfg.streams)
            begin
                if (fill_reg[i] == '0)
                begin
                    any_empty = 1'b1;
                end
                if (fill_reg[i] >= cfg.depth)
                begin
                    some_full = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        ref_next   = ref_reg;
        mism_next  = mism_reg;
        fill_next  = fill_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        emit       = 1'b0;
        res_new    = '0;
        rd_stream  = '0;
        we         = 1'b0;
        q_pop      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                case (cmd_reg.op)
                    OP_PUSH:
                    begin
                        if (out_free)
                        begin
                            emit               = 1'b1;
                            res_new.stream     = cmd_reg.stream;
                            res_new.frm_id     = cmd_reg.frm_id;
                            res_new.buffer_tag = cmd_reg.buffer_tag;
                            res_new.last       = 1'b1;
                            if (push_refused)
                            begin
                                res_new.status = ST_FULL;
                            end
                            else if (push_dropped)
                            begin
                                res_new.status = ST_NONMONO;
                            end
                            else
                            begin
                                res_new.status            = ST_ACCEPTED;
                                we                        = 1'b1;
                                fill_next[cmd_reg.stream] = s_fill + 1'b1;
                                tail_next[cmd_reg.stream] = cmd_reg.frm_id;
                            end
                            state_next = S_IDLE;
                        end
                    end

                    OP_COLLECT:
                    begin
                        if (any_empty)
                        begin
                            if (out_free)
                            begin
                                emit           = 1'b1;
                                res_new.status = ST_NEED;
                                res_new.last   = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            // head of stream 0 is read first
                            rd_stream  = '0;
                            idx_next   = '0;
                            mism_next  = 1'b0;
                            state_next = S_CMP;
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            emit           = 1'b1;
                            res_new.status = ST_FLUSHED;
                            res_new.last   = 1'b1;
                            for (int i = 0; i < MAX_STREAMS; i++)
                            begin
                                fill_next[i] = '0;
                                head_next[i] = '0;
                            end
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_CMP:
            begin
                if (idx_reg == '0)
                begin
                    ref_next = rd_id;
                end
                else if (rd_id != ref_reg)
                begin
                    mism_next = 1'b1;
                end
                if (idx_reg == last_idx)
                begin
                    state_next = S_VERDICT;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    rd_stream = idx_reg + 1'b1;
                end
            end

            S_VERDICT:
            begin
                if (mism_reg)
                begin
                    if (out_free)
                    begin
                        emit           = 1'b1;
                        res_new.status = some_full ? ST_MISMATCH : ST_NEED;
                        res_new.last   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    rd_stream  = '0;
                    idx_next   = '0;
                    state_next = S_REL;
                end
            end

            S_REL:
            begin
                // keep re-reading the current head while the output is held
                rd_stream = idx_reg;
                if (out_free)
                begin
                    emit               = 1'b1;
                    res_new.status     = ST_RELEASED;
                    res_new.stream     = idx_reg;
                    res_new.frm_id     = rd_id;
                    res_new.buffer_tag = rd_tag;
                    res_new.last       = (idx_reg == last_idx);
                    head_next[idx_reg] = head_reg[idx_reg] + 1'b1;
                    fill_next[idx_reg] = fill_reg[idx_reg] - 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        rd_stream = idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mism_reg      <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < MAX_STREAMS; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mism_reg      <= mism_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        ref_reg  <= ref_next;
        tail_reg <= tail_next;
        if (emit)
        begin
            res_reg <= res_new;
        end
    end

    fbsync_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef ASSERT_OFF
    // releasing from a stream that holds nothing would pop garbage
    a_rel_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REL) |-> (fill_reg[idx_reg] != '0))
        else $error("release from empty stream queue");

    // a store write never lands in a queue that is already at capacity
    a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (fill_reg[cmd_reg.stream] < FILL_W'(QUEUE_DEPTH)))
        else $error("write into full stream queue");

    // the final release hands control back to the queue
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REL && emit && res_new.last) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after last release");

    // a new result is only produced into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !emit)
        else $error("result produced over a held result");
`endif

endmodule

`default_nettype wire

@@ hdl/frame_id_barrier_sync_unit.sv @@
// ----------------------------------------------------------------------------
// frame_id_barrier_sync_unit
// Frame id alignment barrier over up to eight streams of (id, tag) queues.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// in        request    in_valid / in_stall  op, stream, frm_id, buffer_tag
// out       result     out_valid/out_stall  status, stream_res, frame_id_res,
//                                           buffer_tag_res, last
// cfg       write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// push and flush go through dispatch and execute in the back end
// collect stops after decide when a queue is empty, else runs an id compare
// pass over the n streams in use and a verdict, then a release pass when
// the heads match: the shared entry store gives one head read per cycle,
// once for the id compare pass and once more for the release pass
// front stage and a 2-entry command queue keep taking requests meanwhile
// a held result stalls the back end, and the front once the queue is full;
// reset clears all queues at once
`default_nettype none

module frame_id_barrier_sync_unit
    import fbsync_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic [STREAM_W-1:0]   stream,
    input  wire logic [ID_W-1:0]       frm_id,
    input  wire logic [TAG_W-1:0]      buffer_tag,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [STATUS_W-1:0]   status,
    output logic      [STREAM_W-1:0]   stream_res,
    output logic      [ID_W-1:0]       frame_id_res,
    output logic      [TAG_W-1:0]      buffer_tag_res,
    output logic                       last,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // raw register values, saturated on use
    logic [CNT_W-1:0]  streams_reg;
    logic [FILL_W-1:0] depth_reg;
    cfg_t              cfg;

    logic              cmd_valid;
    cmd_t              cmd;
    logic              q_full;
    logic              q_valid;
    cmd_t              q_data;
    logic              q_pop;
    res_t              res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streams_reg <= CNT_W'(2);
            depth_reg   <= FILL_W'(QUEUE_DEPTH);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STREAMS:
                begin
                    streams_reg <= cfg_data[CNT_W-1:0];
                end
                CFG_DEPTH:
                begin
                    depth_reg <= cfg_data[FILL_W-1:0];
                end
                default:
                begin
                    streams_reg <= streams_reg;
                end
            endcase
        end
    end

    // clamp to the legal ranges
    always_comb
    begin
        if (streams_reg == '0)
        begin
            cfg.streams = CNT_W'(1);
        end
        else if (streams_reg > CNT_W'(MAX_STREAMS))
        begin
            cfg.streams = CNT_W'(MAX_STREAMS);
        end
        else
        begin
            cfg.streams = streams_reg;
        end

        if (depth_reg == '0)
        begin
            cfg.depth = FILL_W'(1);
        end
        else if (depth_reg > FILL_W'(QUEUE_DEPTH))
        begin
            cfg.depth = FILL_W'(QUEUE_DEPTH);
        end
        else
        begin
            cfg.depth = depth_reg;
        end
    end

    // front: takes requests, drops unknown ops
    fbsync_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .stream     (stream),
        .frm_id     (frm_id),
        .buffer_tag (buffer_tag),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .q_full     (q_full)
    );

    // decoupling queue
    fbsync_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_data  (cmd),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    // back: queue state, entry store, collect sequencer, output register
    fbsync_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign status         = res.status;
    assign stream_res     = res.stream;
    assign frame_id_res   = res.frm_id;
    assign buffer_tag_res = res.buffer_tag;
    assign last           = res.last;

endmodule

`default_nettype wire
